// File: src/bmhq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types, widths and codes for the binary max-heap priority queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

	localparam int DEPTH   = 64;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int CHILD_W = ADDR_W + 2;
	localparam int FILL_W  = 7;
	localparam int PRIO_W  = 32;
	localparam int NODE_W  = 16;

	// operation codes
	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	// result status codes
	localparam logic [1:0] ST_PUSHED  = 2'd0;
	localparam logic [1:0] ST_POPPED  = 2'd1;
	localparam logic [1:0] ST_EMPTY   = 2'd2;
	localparam logic [1:0] ST_DROPPED = 2'd3;

	// read address selection
	localparam logic [1:0] RD_PARENT    = 2'd0;
	localparam logic [1:0] RD_ROOT_TAIL = 2'd1;
	localparam logic [1:0] RD_CHILDREN  = 2'd2;

	// sift-down choice
	localparam logic [1:0] DN_NONE  = 2'd0;
	localparam logic [1:0] DN_LEFT  = 2'd1;
	localparam logic [1:0] DN_RIGHT = 2'd2;

	typedef struct packed {
		logic                     mode;
		logic signed [PRIO_W-1:0] prio_value;
		logic [NODE_W-1:0]        start_node;
		logic [NODE_W-1:0]        end_node;
	} item_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [PRIO_W-1:0] out_prio;
		logic [NODE_W-1:0]        out_start;
		logic [NODE_W-1:0]        out_end;
		logic [FILL_W-1:0]        fill_count;
		logic                     is_empty_flag;
	} result_t;

	typedef struct packed {
		logic signed [PRIO_W-1:0] prio;
		logic [NODE_W-1:0]        start;
		logic [NODE_W-1:0]        stop;
	} entry_t;

	typedef struct packed {
		logic       load_push;
		logic       rd_en;
		logic [1:0] rd_sel;
		logic       up_step;
		logic       place;
		logic       cnt_inc;
		logic       pop_take;
		logic       dn_step;
		logic       finish;
		logic [1:0] code;
	} cmd_t;

	typedef struct packed {
		logic       full;
		logic       empty;
		logic       one_left;
		logic       pos_root;
		logic       up_swap;
		logic [1:0] dn_sel;
	} stat_t;

endpackage

// File: src/bmhq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_dp
// Heap datapath: entry memory, sift position, moving entry, count, compares
// and the result register.
// ----------------------------------------------------------------------------
module bmhq_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  bmhq_pkg::item_t   item,
	input  bmhq_pkg::cmd_t    cmd,
	output bmhq_pkg::stat_t   stat,
	output bmhq_pkg::result_t result,
	output logic              done
);

	bmhq_pkg::entry_t mem_q [bmhq_pkg::DEPTH];
	bmhq_pkg::entry_t rd0_q;
	bmhq_pkg::entry_t rd1_q;
	bmhq_pkg::entry_t mov_q;
	bmhq_pkg::entry_t out_q;
	bmhq_pkg::result_t res_q;
	logic [bmhq_pkg::ADDR_W-1:0] pos_q;
	logic [bmhq_pkg::CNT_W-1:0]  count_q;
	logic                        done_q;

	logic [bmhq_pkg::ADDR_W-1:0]  parent;
	logic [bmhq_pkg::CHILD_W-1:0] left_idx;
	logic [bmhq_pkg::CHILD_W-1:0] right_idx;
	logic [bmhq_pkg::CHILD_W-1:0] count_ext;
	logic                         left_gt;
	logic                         right_gt;
	logic signed [bmhq_pkg::PRIO_W-1:0] best_prio;
	logic [bmhq_pkg::ADDR_W-1:0]  ra0;
	logic [bmhq_pkg::ADDR_W-1:0]  ra1;
	logic                         we;
	logic [bmhq_pkg::ADDR_W-1:0]  waddr;
	bmhq_pkg::entry_t             wdata;
	bmhq_pkg::entry_t             in_entry;

	assign in_entry.prio  = item.prio_value;
	assign in_entry.start = item.start_node;
	assign in_entry.stop  = item.end_node;

	assign parent    = (pos_q - bmhq_pkg::ADDR_W'(1)) >> 1;
	assign left_idx  = {1'b0, pos_q, 1'b1};
	assign right_idx = {1'b0, pos_q, 1'b0} + bmhq_pkg::CHILD_W'(2);
	assign count_ext = bmhq_pkg::CHILD_W'(count_q);

	// strict greater, left child wins ties
	assign left_gt   = (left_idx < count_ext) && (rd0_q.prio > mov_q.prio);
	assign best_prio = left_gt ? rd0_q.prio : mov_q.prio;
	assign right_gt  = (right_idx < count_ext) && (rd1_q.prio > best_prio);

	always_comb begin
		stat.full     = (count_q == bmhq_pkg::CNT_W'(bmhq_pkg::DEPTH));
		stat.empty    = (count_q == '0);
		stat.one_left = (count_q == bmhq_pkg::CNT_W'(1));
		stat.pos_root = (pos_q == '0);
		stat.up_swap  = (mov_q.prio > rd0_q.prio);
		if (right_gt) begin
			stat.dn_sel = bmhq_pkg::DN_RIGHT;
		end else if (left_gt) begin
			stat.dn_sel = bmhq_pkg::DN_LEFT;
		end else begin
			stat.dn_sel = bmhq_pkg::DN_NONE;
		end
	end

	always_comb begin
		ra0 = '0;
		ra1 = '0;
		unique case (cmd.rd_sel)
			bmhq_pkg::RD_PARENT: begin
				ra0 = parent;
			end
			bmhq_pkg::RD_ROOT_TAIL: begin
				ra0 = '0;
				ra1 = bmhq_pkg::ADDR_W'(count_q - bmhq_pkg::CNT_W'(1));
			end
			bmhq_pkg::RD_CHILDREN: begin
				ra0 = left_idx[bmhq_pkg::ADDR_W-1:0];
				ra1 = right_idx[bmhq_pkg::ADDR_W-1:0];
			end
			default: begin
				ra0 = '0;
				ra1 = '0;
			end
		endcase
	end

	// hole-based sift: the moving entry is written only at its final slot
	always_comb begin
		we    = cmd.up_step | cmd.place | cmd.dn_step;
		waddr = pos_q;
		wdata = mov_q;
		if (cmd.up_step) begin
			wdata = rd0_q;
		end else if (cmd.dn_step) begin
			wdata = (stat.dn_sel == bmhq_pkg::DN_RIGHT) ? rd1_q : rd0_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (cmd.rd_en) begin
			rd0_q <= mem_q[ra0];
			rd1_q <= mem_q[ra1];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_push) begin
			mov_q <= in_entry;
			pos_q <= bmhq_pkg::ADDR_W'(count_q);
		end else if (cmd.up_step) begin
			pos_q <= parent;
		end else if (cmd.pop_take) begin
			mov_q <= rd1_q;
			out_q <= rd0_q;
			pos_q <= '0;
		end else if (cmd.dn_step) begin
			pos_q <= (stat.dn_sel == bmhq_pkg::DN_RIGHT) ? right_idx[bmhq_pkg::ADDR_W-1:0]
			                                             : left_idx[bmhq_pkg::ADDR_W-1:0];
		end
		if (cmd.finish) begin
			res_q.status        <= cmd.code;
			res_q.fill_count    <= bmhq_pkg::FILL_W'(count_q);
			res_q.is_empty_flag <= (count_q == '0);
			if (cmd.code == bmhq_pkg::ST_POPPED) begin
				res_q.out_prio  <= out_q.prio;
				res_q.out_start <= out_q.start;
				res_q.out_end   <= out_q.stop;
			end else begin
				res_q.out_prio  <= '0;
				res_q.out_start <= '0;
				res_q.out_end   <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.place && cmd.cnt_inc) begin
				count_q <= count_q + bmhq_pkg::CNT_W'(1);
			end else if (cmd.pop_take) begin
				count_q <= count_q - bmhq_pkg::CNT_W'(1);
			end
		end
	end

	assign result = res_q;
	assign done   = done_q;

endmodule

// File: src/bmhq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Sequencer for push (sift up) and pop (sift down) over the heap datapath.
// ----------------------------------------------------------------------------
module bmhq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            mode,
	input  bmhq_pkg::stat_t stat,
	output bmhq_pkg::cmd_t  cmd,
	output logic            busy
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_UP_RD  = 3'd1;
	localparam logic [2:0] S_UP_CMP = 3'd2;
	localparam logic [2:0] S_POP_LD = 3'd3;
	localparam logic [2:0] S_DN_RD  = 3'd4;
	localparam logic [2:0] S_DN_CMP = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [1:0] code_q;
	logic [1:0] code_d;

	always_comb begin
		state_d = state_q;
		code_d  = code_q;
		cmd     = '0;
		cmd.code = code_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (mode == bmhq_pkg::MODE_PUSH) begin
						if (stat.full) begin
							code_d  = bmhq_pkg::ST_DROPPED;
							state_d = S_DONE;
						end else begin
							cmd.load_push = 1'b1;
							code_d        = bmhq_pkg::ST_PUSHED;
							state_d       = S_UP_RD;
						end
					end else begin
						if (stat.empty) begin
							code_d  = bmhq_pkg::ST_EMPTY;
							state_d = S_DONE;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = bmhq_pkg::RD_ROOT_TAIL;
							code_d     = bmhq_pkg::ST_POPPED;
							state_d    = S_POP_LD;
						end
					end
				end
			end
			S_UP_RD: begin
				if (stat.pos_root) begin
					cmd.place   = 1'b1;
					cmd.cnt_inc = 1'b1;
					state_d     = S_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = bmhq_pkg::RD_PARENT;
					state_d    = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (stat.up_swap) begin
					cmd.up_step = 1'b1;
					state_d     = S_UP_RD;
				end else begin
					cmd.place   = 1'b1;
					cmd.cnt_inc = 1'b1;
					state_d     = S_DONE;
				end
			end
			S_POP_LD: begin
				cmd.pop_take = 1'b1;
				state_d      = stat.one_left ? S_DONE : S_DN_RD;
			end
			S_DN_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = bmhq_pkg::RD_CHILDREN;
				state_d    = S_DN_CMP;
			end
			S_DN_CMP: begin
				if (stat.dn_sel == bmhq_pkg::DN_NONE) begin
					cmd.place = 1'b1;
					state_d   = S_DONE;
				end else begin
					cmd.dn_step = 1'b1;
					state_d     = S_DN_RD;
				end
			end
			S_DONE: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= bmhq_pkg::ST_PUSHED;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

// File: src/binary_max_heap_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_max_heap_queue
// Fixed-capacity binary max-heap of 64 entries (signed priority plus start
// and end identifiers). An operation is taken when start is high and busy is
// low; its result appears for exactly one cycle with done high, and the
// receiver cannot stall it. A push walks up one heap level per parent read
// and compare, a pop walks down one level per read of both children and
// compare, both through a single-write, two-read entry memory with registered
// read data. A dropped push or an empty pop goes straight to the result
// without touching the memory. busy is high from the cycle after the transfer
// and is low again in the cycle in which the result appears.
// ----------------------------------------------------------------------------
module binary_max_heap_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  bmhq_pkg::item_t   item,
	output bmhq_pkg::result_t result,
	output logic              done
);

	bmhq_pkg::cmd_t  cmd;
	bmhq_pkg::stat_t stat;

	bmhq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (item.mode),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	bmhq_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.result (result),
		.done   (done)
	);

endmodule

// File: verif/heap_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heap_result_checker
// Watches the operation and result channels of the max-heap queue, keeps its
// own heap image, and compares every result field by field with the oldest
// predicted one. It reports a mismatch count and the number of results still
// due.
// ----------------------------------------------------------------------------
module heap_result_checker
	import bmhq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    busy,
	input  item_t   item,
	input  result_t result,
	input  logic    done,
	output int      mismatch_count,
	output int      results_due
);

	entry_t  heap_image [DEPTH];
	int      held;
	result_t heap_results_due [$];

	function automatic void swap_entries(int a, int b);
		entry_t t;
		t = heap_image[a];
		heap_image[a] = heap_image[b];
		heap_image[b] = t;
	endfunction

	function automatic result_t heap_apply(item_t op);
		result_t r;
		int      pos;
		int      parent;
		int      best;
		int      child;
		r = '0;
		if (op.mode == MODE_PUSH) begin
			if (held >= DEPTH) begin
				r.status = ST_DROPPED;
			end else begin
				heap_image[held] = '{prio: op.prio_value, start: op.start_node,
					stop: op.end_node};
				pos = held;
				while (pos > 0) begin
					parent = (pos - 1) / 2;
					if (!($signed(heap_image[pos].prio) > $signed(heap_image[parent].prio)))
						break;
					swap_entries(pos, parent);
					pos = parent;
				end
				held++;
				r.status = ST_PUSHED;
			end
		end else begin
			if (held == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.status    = ST_POPPED;
				r.out_prio  = heap_image[0].prio;
				r.out_start = heap_image[0].start;
				r.out_end   = heap_image[0].stop;
				heap_image[0] = heap_image[held - 1];
				held--;
				pos = 0;
				forever begin
					best = pos;
					// left child wins a tie, since the right must be strictly larger
					for (child = 2 * pos + 1; child <= 2 * pos + 2; child++) begin
						if (child < held &&
						    $signed(heap_image[child].prio) > $signed(heap_image[best].prio))
							best = child;
					end
					if (best == pos)
						break;
					swap_entries(pos, best);
					pos = best;
				end
			end
		end
		r.fill_count    = FILL_W'(held);
		r.is_empty_flag = (held == 0);
		return r;
	endfunction

	task automatic flag_field(string field, logic [31:0] want, logic [31:0] got);
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			held = 0;
			heap_results_due.delete();
			mismatch_count = 0;
			results_due = 0;
		end else begin
			if (done) begin
				if (heap_results_due.size() == 0) begin
					$display("%0t: result with no operation pending, actual %0h",
						$time, result);
					mismatch_count++;
				end else begin
					want = heap_results_due.pop_front();
					if (want.status !== result.status)
						flag_field("status", want.status, result.status);
					if (want.out_prio !== result.out_prio)
						flag_field("out_prio", want.out_prio, result.out_prio);
					if (want.out_start !== result.out_start)
						flag_field("out_start", want.out_start, result.out_start);
					if (want.out_end !== result.out_end)
						flag_field("out_end", want.out_end, result.out_end);
					if (want.fill_count !== result.fill_count)
						flag_field("fill_count", want.fill_count, result.fill_count);
					if (want.is_empty_flag !== result.is_empty_flag)
						flag_field("is_empty_flag", want.is_empty_flag, result.is_empty_flag);
				end
			end
			// a transfer at this edge is predicted after the result compare
			if (start && !busy)
				heap_results_due.push_back(heap_apply(item));
			results_due = heap_results_due.size();
		end
	end

endmodule

// File: verif/binary_max_heap_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_max_heap_queue_tb
// Drives pushes and pops into the max-heap queue: a directed opening on
// priority extremes, ties and empty pops, then random bursts biased toward
// filling or draining so that full drops and empty pops recur. A checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module binary_max_heap_queue_tb;
	import bmhq_pkg::*;

	localparam int RANDOM_OPS  = 1800;
	localparam int CYCLE_LIMIT = 400000;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	logic    busy;
	item_t   item = '0;
	result_t result;
	logic    done;
	int      mismatch_count;
	int      results_due;
	int      cycles = 0;
	bit      gaps_on = 1'b1;

	binary_max_heap_queue DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.result (result),
		.done   (done)
	);

	heap_result_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.item           (item),
		.result         (result),
		.done           (done),
		.mismatch_count (mismatch_count),
		.results_due    (results_due)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	function automatic item_t make_op(logic mode, logic [31:0] prio, logic [15:0] s,
		logic [15:0] e);
		item_t op;
		op.mode       = mode;
		op.prio_value = prio;
		op.start_node = s;
		op.end_node   = e;
		return op;
	endfunction

	function automatic logic [31:0] pick_prio();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 60)
			return $urandom;
		else if (sel < 85)
			return 32'($signed($urandom_range(0, 7)) - 4); // dense range, many ties
		else
			case ($urandom_range(0, 3))
				0: return 32'h7FFF_FFFF;
				1: return 32'h8000_0000;
				2: return 32'h0000_0000;
				default: return 32'hFFFF_FFFF;
			endcase
	endfunction

	// called at a falling edge; returns at the falling edge after the transfer, or after a random idle gap
	task automatic issue_op(input item_t op);
		start <= 1'b1;
		item  <= op;
		while (busy)
			@(negedge clk);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 99) < 6) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6))
				@(negedge clk);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(negedge clk);
		while (results_due != 0)
			@(negedge clk);
	endtask

	initial begin
		int sent;
		int burst;
		int push_pct;
		repeat (3)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty pop, priority extremes, ties, drain past empty
		issue_op(make_op(MODE_POP, 32'h1234_5678, 16'hFFFF, 16'hFFFF));
		issue_op(make_op(MODE_PUSH, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF));
		issue_op(make_op(MODE_PUSH, 32'h8000_0000, 16'h0000, 16'h0000));
		issue_op(make_op(MODE_PUSH, 32'h0000_0000, 16'hA5A5, 16'h5A5A));
		issue_op(make_op(MODE_PUSH, 32'hFFFF_FFFF, 16'h5A5A, 16'hA5A5));
		issue_op(make_op(MODE_PUSH, 32'd5, 16'd1, 16'd1));
		issue_op(make_op(MODE_PUSH, 32'd5, 16'd2, 16'd2));
		issue_op(make_op(MODE_PUSH, 32'd5, 16'd3, 16'd3));
		issue_op(make_op(MODE_PUSH, 32'd5, 16'd4, 16'd4));
		issue_op(make_op(MODE_PUSH, 32'h8000_0000, 16'hFFFF, 16'h0000));
		repeat (10)
			issue_op(make_op(MODE_POP, $urandom, 16'($urandom_range(0, 65535)),
				16'($urandom_range(0, 65535))));
		wait_drained();

		// random bursts: push-heavy ones run into full, pop-heavy ones into empty
		sent = 0;
		while (sent < RANDOM_OPS) begin
			case ($urandom_range(0, 4))
				0: push_pct = 95;
				1: push_pct = 70;
				2: push_pct = 50;
				3: push_pct = 30;
				default: push_pct = 8;
			endcase
			if ($urandom_range(0, 3) == 0)
				wait_drained();
			burst = $urandom_range(30, 120);
			repeat (burst) begin
				gaps_on = !(sent >= 700 && sent < 1100);
				issue_op(make_op(($urandom_range(0, 99) < push_pct) ? MODE_PUSH : MODE_POP,
					pick_prio(),
					($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535)),
					($urandom_range(0, 9) == 0) ? 16'h0000 : 16'($urandom_range(0, 65535))));
				sent++;
			end
		end

		wait_drained();
		repeat (30)
			@(negedge clk);
		if (mismatch_count == 0 && results_due == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
